// ===== src/bms_pkg.sv =====
// ----------------------------------------------------------------------------
// bms_pkg: shared types for the bounded multiset store
// Command codes, sequencer states and the layout of one stored slot.
// ----------------------------------------------------------------------------
package bms_pkg;

    localparam int VALUE_W = 32;
    localparam int CMD_W   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD      = 2'd0,
        CMD_CONTAINS = 2'd1,
        CMD_REMOVE   = 2'd2,
        CMD_CLEAR    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    // One slot of the store: valid bit above the raw value bits
    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

endpackage

// ===== src/bms_ram.sv =====
// ----------------------------------------------------------------------------
// bms_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bms_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/bms_cmp.sv =====
// ----------------------------------------------------------------------------
// bms_cmp: shared slot comparator
// Flags a free slot for add, or a valid slot holding the value for contains and remove.
// ----------------------------------------------------------------------------
module bms_cmp (
    input  bms_pkg::cmd_t                 cmd,
    input  logic [bms_pkg::VALUE_W-1:0]   value,
    input  bms_pkg::slot_t                slot,
    input  logic                          slot_ok,
    output logic                          hit
);

    always_comb begin
        hit = 1'b0;
        if (slot_ok) begin
            unique case (cmd)
                bms_pkg::CMD_ADD:      hit = !slot.valid;
                bms_pkg::CMD_CONTAINS,
                bms_pkg::CMD_REMOVE:   hit = slot.valid && (slot.value == value);
                default:               hit = 1'b0;
            endcase
        end
    end

endmodule

// ===== src/bounded_multiset_store.sv =====
// ----------------------------------------------------------------------------
// bounded_multiset_store: bag of 32-bit values in CAPACITY slots
// Add, contains, remove-one and clear, each answered with one result.
// ----------------------------------------------------------------------------
// Each slot (valid bit plus value) lives in one RAM with a registered read
// port, and one comparator walks the slots in order, one slot per cycle.
// Add, contains and remove stop at the first hit, so a command that hits a
// later slot takes longer to finish; the single RAM read port and the shared
// comparator set this pace. Clear writes every slot invalid, one slot per
// cycle. After reset the same pass runs over every slot, during which
// s_tready stays low. The result sits in an output register, so a finished
// result may wait on m_tready while the next command is accepted; the block
// then holds in its finish step until the output register is free.
// Duplicate values take separate slots.
// ----------------------------------------------------------------------------
module bounded_multiset_store #(
    parameter int CAPACITY = 16,
    localparam int CNT_W   = $clog2(CAPACITY + 1),
    localparam int OUT_W   = ((2 + CNT_W + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,

    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [39:0]      s_tdata,   // [1:0] command, [33:2] value, rest zero

    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // [0] found, [1] dropped, then count, rest zero
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    // Sequencer state
    bms_pkg::state_t state_reg, state_next;

    // Current command
    bms_pkg::cmd_t                 cmd_reg;
    logic [bms_pkg::VALUE_W-1:0]   value_reg;

    // Scan / sweep address, and the slot the RAM output belongs to
    logic [AW-1:0] addr_reg;
    logic [AW-1:0] cmp_idx_reg;
    logic          cmp_ok_reg;
    logic          sweep_res_reg;   // sweep ends in a result (clear command)

    // Running state of the bag and the pending result
    logic [CNT_W-1:0] count_reg;
    logic             found_reg;
    logic             dropped_reg;

    // Output register
    logic             m_tvalid_reg;
    logic             m_found_reg;
    logic             m_dropped_reg;
    logic [CNT_W-1:0] m_count_reg;

    // RAM and comparator
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    bms_pkg::slot_t         ram_wdata;
    bms_pkg::slot_t         ram_rdata;
    logic                   hit;

    // Control decoded from the state
    logic in_accept;
    logic scan_done;
    logic out_free;
    logic load_out;

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign scan_done = cmp_ok_reg && (hit || (cmp_idx_reg == LAST_IDX));

    bms_ram #(
        .WIDTH (bms_pkg::SLOT_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    bms_cmp u_cmp (
        .cmd     (cmd_reg),
        .value   (value_reg),
        .slot    (ram_rdata),
        .slot_ok (cmp_ok_reg),
        .hit     (hit)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bms_pkg::ST_IDLE: begin
                if (in_accept) begin
                    if (bms_pkg::cmd_t'(s_tdata[1:0]) == bms_pkg::CMD_CLEAR) begin
                        state_next = bms_pkg::ST_SWEEP;
                    end else begin
                        state_next = bms_pkg::ST_SCAN;
                    end
                end
            end
            bms_pkg::ST_SCAN: begin
                if (scan_done) begin
                    state_next = bms_pkg::ST_FINISH;
                end
            end
            bms_pkg::ST_SWEEP: begin
                if (addr_reg == LAST_IDX) begin
                    state_next = sweep_res_reg ? bms_pkg::ST_FINISH : bms_pkg::ST_IDLE;
                end
            end
            bms_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = bms_pkg::ST_IDLE;
                end
            end
            default: state_next = bms_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        s_tready  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = cmp_idx_reg;
        ram_wdata = '{valid: 1'b0, value: value_reg};
        load_out  = 1'b0;
        unique case (state_reg)
            bms_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            bms_pkg::ST_SCAN: begin
                // Add fills the free slot, remove drops the matching one
                if (cmp_ok_reg && hit && (cmd_reg != bms_pkg::CMD_CONTAINS)) begin
                    ram_we    = 1'b1;
                    ram_wdata = '{valid: (cmd_reg == bms_pkg::CMD_ADD), value: value_reg};
                end
            end
            bms_pkg::ST_SWEEP: begin
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
            end
            bms_pkg::ST_FINISH: begin
                load_out = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bms_pkg::ST_SWEEP;
            addr_reg      <= '0;
            cmp_ok_reg    <= 1'b0;
            sweep_res_reg <= 1'b0;
            count_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;

            // Advance the scan or sweep address, wrapping at the last slot
            if (state_reg == bms_pkg::ST_IDLE) begin
                addr_reg   <= '0;
                cmp_ok_reg <= 1'b0;
            end else begin
                addr_reg   <= (addr_reg == LAST_IDX) ? '0 : addr_reg + AW'(1);
                cmp_ok_reg <= (state_reg == bms_pkg::ST_SCAN) && !scan_done;
            end

            if (in_accept) begin
                sweep_res_reg <= 1'b1;
                if (bms_pkg::cmd_t'(s_tdata[1:0]) == bms_pkg::CMD_CLEAR) begin
                    count_reg <= '0;
                end
            end

            if (state_reg == bms_pkg::ST_SCAN && cmp_ok_reg && hit) begin
                unique case (cmd_reg)
                    bms_pkg::CMD_ADD:    count_reg <= count_reg + CNT_ONE;
                    bms_pkg::CMD_REMOVE: count_reg <= count_reg - CNT_ONE;
                    default:             count_reg <= count_reg;
                endcase
            end

            // Hold the result until the output side takes it
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            cmd_reg     <= bms_pkg::cmd_t'(s_tdata[1:0]);
            value_reg   <= s_tdata[33:2];
            found_reg   <= 1'b0;
            dropped_reg <= 1'b0;
        end
        cmp_idx_reg <= addr_reg;
        if (state_reg == bms_pkg::ST_SCAN && scan_done) begin
            found_reg   <= hit && (cmd_reg != bms_pkg::CMD_ADD);
            dropped_reg <= !hit && (cmd_reg == bms_pkg::CMD_ADD);
        end
        if (load_out) begin
            m_found_reg   <= found_reg;
            m_dropped_reg <= dropped_reg;
            m_count_reg   <= count_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({m_count_reg, m_dropped_reg, m_found_reg});

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for bounded_multiset_store
// Drives add, contains, remove and clear transactions through the input
// stream, predicts each reply from a private copy of the bag, and compares
// every reply field by field. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;
    localparam int CHUNKS      = 19;
    localparam int CHUNK_ITEMS = 100;

    // One command as it travels on the input stream
    typedef struct {
        bms_pkg::cmd_t op;
        logic [31:0]   operand;
    } bag_cmd_t;

    // One reply as it comes back on the output stream
    typedef struct {
        bit       found;
        bit       dropped;
        bit [4:0] count;
    } bag_reply_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;  // [1:0] command, [33:2] value, [39:34] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // [0] found, [1] dropped, [6:2] count, [7] zero

    bounded_multiset_store #(
        .CAPACITY(SLOTS)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Bag predictor: its own copy of the slots, updated once per accepted
    // transaction, in acceptance order.
    // ------------------------------------------------------------------------
    bit [31:0] bag_value [SLOTS];
    bit        bag_used  [SLOTS];
    bit [4:0]  bag_count = '0;

    function automatic bag_reply_t apply_command(bag_cmd_t c);
        bag_reply_t r;
        int         hit;
        r   = '{default: 0};
        hit = -1;
        case (c.op)
            bms_pkg::CMD_ADD: begin
                // take the lowest free slot; a full bag drops the value
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!bag_used[i]) hit = i;
                if (hit >= 0) begin
                    bag_value[hit] = c.operand;
                    bag_used[hit]  = 1'b1;
                    bag_count++;
                end else begin
                    r.dropped = 1'b1;
                end
            end
            bms_pkg::CMD_CONTAINS, bms_pkg::CMD_REMOVE: begin
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (bag_used[i] && bag_value[i] == c.operand) hit = i;
                r.found = (hit >= 0);
                // remove deletes exactly one copy of the value
                if (c.op == bms_pkg::CMD_REMOVE && hit >= 0) begin
                    bag_used[hit] = 1'b0;
                    bag_count--;
                end
            end
            default: begin
                foreach (bag_used[i]) bag_used[i] = 1'b0;
                bag_count = '0;
            end
        endcase
        r.count = bag_count;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Queues shared by the stimulus, driver and monitor
    // ------------------------------------------------------------------------
    bag_cmd_t   pending_cmds[$];     // filled by the stimulus, drained by the driver
    bag_reply_t expected_replies[$]; // predictions awaiting their reply
    bag_cmd_t   cur_cmd;             // command currently offered on s_tdata
    bit         tx_busy    = 1'b0;   // s_tvalid is up with an unaccepted command
    int         error_count = 0;
    int         cycle_count = 0;

    // ------------------------------------------------------------------------
    // Sender: bursts of random length separated by random gaps. Change inputs
    // on the falling edge only; hold the command until it is accepted.
    // ------------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge aclk) begin
        if (aresetn && !tx_busy) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                cur_cmd = pending_cmds.pop_front();
                s_tdata <= {6'b0, cur_cmd.operand, cur_cmd.op};
                s_tvalid <= 1'b1;
                tx_busy = 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    // a third of the bursts follow on back to back
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: a countdown timer picks the stall pattern anew from always ready,
    // coin flip, and mostly stalled.
    // ------------------------------------------------------------------------
    int stall_mode = 0;
    int mode_timer = 0;

    always @(negedge aclk) begin
        if (mode_timer == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_timer = 64;
        end
        mode_timer--;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // ------------------------------------------------------------------------
    // Monitor: sample both handshakes on the rising edge. Predict on input
    // acceptance, compare on output acceptance.
    // ------------------------------------------------------------------------
    task automatic report_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("tb: error: %s", msg);
    endtask

    always @(posedge aclk) begin
        bag_reply_t want;
        if (aresetn && s_tvalid && s_tready) begin
            expected_replies.push_back(apply_command(cur_cmd));
            tx_busy = 1'b0;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_replies.size() == 0) begin
                report_error($sformatf("reply %02h with nothing expected", m_tdata));
            end else begin
                want = expected_replies.pop_front();
                if (m_tdata[0] !== want.found)
                    report_error($sformatf("found: expected %0b, got %0b",
                                           want.found, m_tdata[0]));
                if (m_tdata[1] !== want.dropped)
                    report_error($sformatf("dropped: expected %0b, got %0b",
                                           want.dropped, m_tdata[1]));
                if (m_tdata[6:2] !== want.count)
                    report_error($sformatf("count: expected %0d, got %0d",
                                           want.count, m_tdata[6:2]));
            end
        end
    end

    // Give up on a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic queue_cmd(bms_pkg::cmd_t op, logic [31:0] operand);
        pending_cmds.push_back('{op: op, operand: operand});
    endtask

    // Hold until every queued command is accepted and every reply is back
    task automatic drain_bag();
        while (pending_cmds.size() != 0 || tx_busy || expected_replies.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        bit [31:0]     pool [8];
        int            pool_size;
        int            add_pct;
        int            pick;
        bms_pkg::cmd_t op;
        logic [31:0]   operand;

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty bag, value extremes, duplicates, removal misses,
        // filling to capacity, drop on full, clear.
        queue_cmd(bms_pkg::CMD_CLEAR,    32'h0000_0000);
        queue_cmd(bms_pkg::CMD_CONTAINS, 32'h0000_0000);
        queue_cmd(bms_pkg::CMD_ADD,      32'h8000_0000);
        queue_cmd(bms_pkg::CMD_ADD,      32'h7FFF_FFFF);
        queue_cmd(bms_pkg::CMD_ADD,      32'h0000_0000);
        queue_cmd(bms_pkg::CMD_ADD,      32'hFFFF_FFFF);
        queue_cmd(bms_pkg::CMD_ADD,      32'h7FFF_FFFF);
        queue_cmd(bms_pkg::CMD_CONTAINS, 32'hFFFF_FFFF);
        queue_cmd(bms_pkg::CMD_CONTAINS, 32'hFFFF_FFFE);
        queue_cmd(bms_pkg::CMD_REMOVE,   32'h7FFF_FFFF);
        queue_cmd(bms_pkg::CMD_REMOVE,   32'h1234_5678);
        queue_cmd(bms_pkg::CMD_CONTAINS, 32'h7FFF_FFFF);
        for (int i = 0; i < 12; i++)
            queue_cmd(bms_pkg::CMD_ADD, 32'h1 << i);
        queue_cmd(bms_pkg::CMD_ADD,      32'hDEAD_BEEF);
        queue_cmd(bms_pkg::CMD_CLEAR,    32'hFFFF_FFFF);

        // Hold the stimulus until the bag is quiet
        drain_bag();

        // Random: each chunk draws a small pool of values so lookups and
        // removals hit, plus some fully random values as noise.
        for (int chunk = 0; chunk < CHUNKS; chunk++) begin
            pool_size = $urandom_range(2, 8);
            add_pct   = $urandom_range(25, 55);
            for (int i = 0; i < 8; i++) begin
                case ($urandom_range(0, 5))
                    0:       pool[i] = 32'h8000_0000;
                    1:       pool[i] = 32'h7FFF_FFFF;
                    2:       pool[i] = 32'hFFFF_FFFF;
                    default: pool[i] = $urandom;
                endcase
            end
            for (int n = 0; n < CHUNK_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < add_pct)                           op = bms_pkg::CMD_ADD;
                else if (pick < add_pct + (95 - add_pct) / 2) op = bms_pkg::CMD_CONTAINS;
                else if (pick < 95)                           op = bms_pkg::CMD_REMOVE;
                else                                          op = bms_pkg::CMD_CLEAR;
                if ($urandom_range(0, 99) < 15)
                    operand = $urandom;
                else
                    operand = pool[$urandom_range(0, pool_size - 1)];
                queue_cmd(op, operand);
            end
            // Drain once midway as well, and keep the queue short otherwise
            if (chunk == CHUNKS / 2)
                drain_bag();
            else
                while (pending_cmds.size() > 50) @(posedge aclk);
        end

        drain_bag();
        repeat (40) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
